// ===== hw/rtl/sfd_pkg.sv =====
// Shared types, constants and the tanh table for the stereo feedback delay.
package sfd_pkg;

  // Sample and register widths
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned DELAY_W    = 14;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned MIX_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register limits and reset values
  localparam int unsigned DELAY_MASK = 16383;
  localparam int unsigned DELAY_RST  = 8192;
  localparam int unsigned GAIN_MAX   = 18022;
  localparam int unsigned GAIN_RST   = 8192;
  localparam int unsigned MIX_ONE    = 32768;
  localparam int unsigned MIX_RST    = 16384;

  // Fixed-point scaling
  localparam int unsigned MIX_FRAC   = 15;
  localparam int          MIX_RND    = 16384;
  localparam int unsigned IN_ARG_SH  = 14;
  localparam int unsigned ARG_SH     = 21;
  localparam int          ARG_RND    = 1048576;
  localparam int          SAMPLE_MAX = 32767;
  localparam int          SAMPLE_MIN = -32768;

  // Soft-clip table: |k| in 0..1024, k saturated to -1024..1023
  localparam int unsigned TANH_STEPS = 1024;
  localparam int          K_MAX      = 1023;
  localparam int          K_MIN      = -1024;
  localparam int unsigned K_W        = 11;
  localparam int unsigned TANH_W     = 15;

  // Pipeline and output queue
  localparam int unsigned PIPE_STAGES = 4;
  localparam int unsigned OQ_DEPTH    = 4;
  localparam int unsigned OQ_PTR_W    = 2;
  localparam int unsigned OQ_CNT_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_L = 2'd0,
    CFG_DELAY_R = 2'd1,
    CFG_GAIN    = 2'd2,
    CFG_MIX     = 2'd3
  } cfg_idx_e;

  // Per-channel control from the top level
  typedef struct packed {
    logic acc;     // item accepted, read issued this cycle
    logic ent_ok;  // entry read for the item in stage 1 was ever written
    logic wr_en;   // write-back from stage 4
  } sfd_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } sfd_pair_t;

  typedef logic [TANH_W-1:0] tanh_tab_t [TANH_STEPS+1];

  // Unsigned 64-bit long division, only evaluated while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // T(k) = round(32767*tanh(k/256)) = round(32767*(1-p)/(1+p)), p = e^(-k/128),
  // built at elaboration in Q62 integer arithmetic
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t    tab;
    logic [63:0]  one;
    logic [63:0]  term;
    logic [63:0]  q;
    logic [63:0]  p;
    logic [63:0]  p40;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  n;
    logic [127:0] prod;
    int           k;
    one  = 64'd1 << 62;
    term = one;
    q    = one;
    p    = one;
    // q = e^(-1/128) from its series
    for (n = 64'd1; term != 64'd0 && n < 64'd64; n++) begin
      term = udiv64(term, 64'd128 * n);
      if (n[0]) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (k = 0; k <= int'(TANH_STEPS); k++) begin
      p40     = (p + (64'd1 << 21)) >> 22;
      num     = 64'd32767 * ((64'd1 << 40) - p40);
      den     = (64'd1 << 40) + p40;
      tab[k]  = TANH_W'(udiv64(64'd2 * num + den, 64'd2 * den));
      prod    = {64'd0, p} * {64'd0, q};
      prod    = prod + (128'd1 << 61);
      p       = prod[125:62];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

// ===== hw/rtl/stereo_feedback_delay_top.sv =====
// Stereo feedback delay line with soft-clipped feedback: top level.
//
// One stereo Q1.15 pair per item. Each channel reads its delay memory at the
// write pointer minus its delay, emits the rounded wet/dry mix and writes the
// tanh-clipped feedback back at the write pointer from stage 4. Results go
// from stage 2 into a four-entry output queue, so input keeps flowing while
// the output side stalls, until the queue credit runs out. With both delays
// above four samples an item is taken every cycle while the output keeps up;
// a shorter delay reads an entry whose write-back is still in the pipeline,
// and the read-after-write interlock on the delay memory then holds the next
// item until that write-back is done. Entries never written since reset read
// as zero through the write pointer's wrap flag, so the memories need no
// clearing pass and the block is ready straight after reset. Delay, gain and
// mix registers must be written only while the block is idle (not enforced).
module stereo_feedback_delay_top #(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sfd_pkg::DATA_W-1:0]   in_left_i,
  input  logic signed [sfd_pkg::DATA_W-1:0]   in_right_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sfd_pkg::DATA_W-1:0]   out_left_o,
  output logic signed [sfd_pkg::DATA_W-1:0]   out_right_o,
  input  logic                                cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import sfd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
  localparam logic [DELAY_W-1:0] DelayMax =
      (DEPTH - 1 > DELAY_MASK) ? DELAY_W'(DELAY_MASK) : DELAY_W'(DEPTH - 1);
  localparam logic [DELAY_W-1:0] DelayRst =
      (DELAY_RST > DEPTH - 1) ? DelayMax : DELAY_W'(DELAY_RST);
  localparam logic [AW-1:0] PtrLast = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DepthSw = SW'(DEPTH);

  // Configuration
  logic [DELAY_W-1:0] delay_l_q;
  logic [DELAY_W-1:0] delay_r_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [MIX_W-1:0]   mix_q;

  // Write pointer and wrap flag
  logic [AW-1:0] wp_q;
  logic          wrapped_q;

  // Pipeline bookkeeping, index 0 is stage 1
  logic          v_q  [PIPE_STAGES];
  logic [AW-1:0] wa_q [PIPE_STAGES];
  logic          ent_ok_l_q;
  logic          ent_ok_r_q;

  // Output queue
  sfd_pair_t             oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_rd_q;
  logic [OQ_PTR_W-1:0]   oq_wr_q;
  logic [OQ_CNT_W-1:0]   oq_cnt_q;

  logic [AW-1:0]         rd_l;
  logic [AW-1:0]         rd_r;
  logic                  haz_l;
  logic                  haz_r;
  logic                  credit_ok;
  logic                  acc;
  logic                  push;
  logic                  pop;
  logic signed [DATA_W-1:0] mix_l;
  logic signed [DATA_W-1:0] mix_r;
  sfd_ctl_t              ctl_l;
  sfd_ctl_t              ctl_r;

  function automatic logic [DELAY_W-1:0] clamp_delay(input logic [DELAY_W-1:0] v);
    logic [DELAY_W-1:0] r;
    if (v == '0) begin
      r = DELAY_W'(1);
    end else if (v > DelayMax) begin
      r = DelayMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Ring position wp - dly, wrapping at DEPTH
  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] wp,
                                              input logic [DELAY_W-1:0] dly);
    logic [SW-1:0] d;
    d = SW'(wp) - SW'(dly);
    if (d[SW-1]) begin
      d = d + DepthSw;
    end
    return d[AW-1:0];
  endfunction

  // Read addresses, the interlock against pending write-backs and queue credit
  always_comb begin
    rd_l  = ring_sub(wp_q, delay_l_q);
    rd_r  = ring_sub(wp_q, delay_r_q);
    haz_l = 1'b0;
    haz_r = 1'b0;
    for (int s = 0; s < int'(PIPE_STAGES); s++) begin
      haz_l = haz_l | (v_q[s] && (wa_q[s] == rd_l));
      haz_r = haz_r | (v_q[s] && (wa_q[s] == rd_r));
    end
    credit_ok = (4'(oq_cnt_q) + 4'(v_q[0]) + 4'(v_q[1])) < 4'(OQ_DEPTH);
  end

  assign in_stall_o  = haz_l | haz_r | ~credit_ok;
  assign acc         = in_valid_i & ~in_stall_o;
  assign push        = v_q[1];
  assign out_valid_o = (oq_cnt_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_left_o  = oq_q[oq_rd_q].left;
  assign out_right_o = oq_q[oq_rd_q].right;

  assign ctl_l = '{acc: acc, ent_ok: ent_ok_l_q, wr_en: v_q[PIPE_STAGES-1]};
  assign ctl_r = '{acc: acc, ent_ok: ent_ok_r_q, wr_en: v_q[PIPE_STAGES-1]};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_l_q <= DelayRst;
      delay_r_q <= DelayRst;
      gain_q    <= GAIN_W'(GAIN_RST);
      mix_q     <= MIX_W'(MIX_RST);
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      for (int s = 0; s < int'(PIPE_STAGES); s++) begin
        v_q[s] <= 1'b0;
      end
      oq_rd_q   <= '0;
      oq_wr_q   <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_DELAY_L: delay_l_q <= clamp_delay(cfg_wdata_i[DELAY_W-1:0]);
          CFG_DELAY_R: delay_r_q <= clamp_delay(cfg_wdata_i[DELAY_W-1:0]);
          CFG_GAIN: begin
            gain_q <= (cfg_wdata_i[GAIN_W-1:0] > GAIN_W'(GAIN_MAX)) ?
                      GAIN_W'(GAIN_MAX) : cfg_wdata_i[GAIN_W-1:0];
          end
          CFG_MIX: begin
            mix_q <= (cfg_wdata_i[MIX_W-1:0] > MIX_W'(MIX_ONE)) ?
                     MIX_W'(MIX_ONE) : cfg_wdata_i[MIX_W-1:0];
          end
          default: ;
        endcase
      end
      // Pointer advance per accepted item
      if (acc) begin
        if (wp_q == PtrLast) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AW'(1);
        end
      end
      v_q[0] <= acc;
      for (int s = 1; s < int'(PIPE_STAGES); s++) begin
        v_q[s] <= v_q[s-1];
      end
      // Output queue pointers
      if (push) begin
        oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      end
      if (pop) begin
        oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
      end
      if (push && !pop) begin
        oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
      end else if (pop && !push) begin
        oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
      end
    end
  end

  // Payload: write addresses, entry-written flags, queued results
  always_ff @(posedge clk_i) begin
    wa_q[0]    <= wp_q;
    for (int s = 1; s < int'(PIPE_STAGES); s++) begin
      wa_q[s] <= wa_q[s-1];
    end
    ent_ok_l_q <= wrapped_q || (rd_l < wp_q);
    ent_ok_r_q <= wrapped_q || (rd_r < wp_q);
    if (push) begin
      oq_q[oq_wr_q] <= '{left: mix_l, right: mix_r};
    end
  end

  sfd_chan #(
    .DEPTH (DEPTH)
  ) u_chan_l (
    .clk_i     (clk_i),
    .ctl_i     (ctl_l),
    .rd_addr_i (rd_l),
    .wr_addr_i (wa_q[PIPE_STAGES-1]),
    .in_i      (in_left_i),
    .mix_i     (mix_q),
    .gain_i    (gain_q),
    .mix_o     (mix_l)
  );

  sfd_chan #(
    .DEPTH (DEPTH)
  ) u_chan_r (
    .clk_i     (clk_i),
    .ctl_i     (ctl_r),
    .rd_addr_i (rd_r),
    .wr_addr_i (wa_q[PIPE_STAGES-1]),
    .in_i      (in_right_i),
    .mix_i     (mix_q),
    .gain_i    (gain_q),
    .mix_o     (mix_r)
  );

endmodule

// ===== hw/rtl/sfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module sfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sfd_chan.sv =====
// One channel: delay memory, wet/dry mix and soft-clipped feedback write-back.
module sfd_chan #(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                             clk_i,
  input  sfd_pkg::sfd_ctl_t                ctl_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic signed [sfd_pkg::DATA_W-1:0] in_i,
  input  logic [sfd_pkg::MIX_W-1:0]        mix_i,
  input  logic [sfd_pkg::GAIN_W-1:0]       gain_i,
  output logic signed [sfd_pkg::DATA_W-1:0] mix_o
);
  import sfd_pkg::*;

  localparam int unsigned PM_W  = (MIX_W + 2) + (DATA_W + 1);
  localparam int unsigned PF_W  = DATA_W + GAIN_W + 1;
  localparam int unsigned MAC_W = PM_W + 1;
  localparam int unsigned ARG_W = PF_W + 2;

  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] wr_data;

  // Stage 1
  logic signed [DATA_W-1:0] in1_q;
  logic signed [DATA_W-1:0] dly;
  logic signed [DATA_W:0]   diff;

  // Stage 2
  logic signed [DATA_W-1:0] in2_q;
  logic signed [PM_W-1:0]   pm2_q;
  logic signed [PF_W-1:0]   pf2_q;
  logic signed [MAC_W-1:0]  mac;
  logic signed [MAC_W-1:0]  mac_sh;
  logic signed [ARG_W-1:0]  arg;
  logic signed [ARG_W-1:0]  k_sh;
  logic signed [ARG_W-1:0]  k_sat;
  logic                     k_neg;
  logic [K_W-1:0]           k_abs;

  // Stages 3 and 4
  logic [K_W-1:0]           kabs3_q;
  logic                     neg3_q;
  logic [TANH_W-1:0]        t4_q;
  logic                     neg4_q;

  sfd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data),
    .re_i    (ctl_i.acc),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // Stage 1: delayed sample, zero for entries never written
  always_comb begin
    dly  = ctl_i.ent_ok ? signed'(rd_data) : '0;
    diff = (DATA_W + 1)'(dly) - (DATA_W + 1)'(in1_q);
  end

  // (1-m)*in + m*d is folded to in + m*(d-in): one product per path
  always_ff @(posedge clk_i) begin
    in1_q <= in_i;
    in2_q <= in1_q;
    pm2_q <= $signed({2'b00, mix_i}) * diff;
    pf2_q <= dly * $signed({1'b0, gain_i});
  end

  // Stage 2: mix rounding and saturation, feedback argument to table index
  always_comb begin
    mac    = (MAC_W'(in2_q) <<< MIX_FRAC) + MAC_W'(pm2_q) + MAC_W'(MIX_RND);
    mac_sh = mac >>> MIX_FRAC;
    if (mac_sh > MAC_W'(SAMPLE_MAX)) begin
      mix_o = DATA_W'(SAMPLE_MAX);
    end else if (mac_sh < MAC_W'(SAMPLE_MIN)) begin
      mix_o = DATA_W'(SAMPLE_MIN);
    end else begin
      mix_o = DATA_W'(mac_sh);
    end

    arg  = (ARG_W'(in2_q) <<< IN_ARG_SH) + ARG_W'(pf2_q) + ARG_W'(ARG_RND);
    k_sh = arg >>> ARG_SH;
    if (k_sh > ARG_W'(K_MAX)) begin
      k_sat = ARG_W'(K_MAX);
    end else if (k_sh < ARG_W'(K_MIN)) begin
      k_sat = ARG_W'(K_MIN);
    end else begin
      k_sat = k_sh;
    end
    k_neg = k_sat[ARG_W-1];
    k_abs = k_neg ? K_W'(-k_sat) : K_W'(k_sat);
  end

  // Stage 3: table lookup on |k|; stage 4: sign restored, written back
  always_ff @(posedge clk_i) begin
    kabs3_q <= k_abs;
    neg3_q  <= k_neg;
    t4_q    <= TANH_TAB[kabs3_q];
    neg4_q  <= neg3_q;
  end

  assign wr_data = neg4_q ? -$signed({1'b0, t4_q}) : $signed({1'b0, t4_q});

endmodule

// ===== hw/rtl/sfd_checker.sv =====
// Port-level checks for the stereo feedback delay, bound to the top level.
module sfd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_i,
  input logic                               out_valid_i,
  input logic                               out_stall_i,
  input logic signed [sfd_pkg::DATA_W-1:0]  out_left_i,
  input logic signed [sfd_pkg::DATA_W-1:0]  out_right_i
);
  import sfd_pkg::*;

  logic [OQ_CNT_W:0] outs_q;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid_i & ~in_stall_i;
  assign out_acc = out_valid_i & ~out_stall_i;

  // Items taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outs_q <= '0;
    end else if (in_acc && !out_acc) begin
      outs_q <= outs_q + (OQ_CNT_W + 1)'(1);
    end else if (out_acc && !in_acc) begin
      outs_q <= outs_q - (OQ_CNT_W + 1)'(1);
    end
  end

  // No result without an item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (outs_q != '0))
    else $error("result offered with no item outstanding");

  // Output queue credit bounds the items in flight
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outs_q <= (OQ_CNT_W + 1)'(OQ_DEPTH))
    else $error("more items in flight than output queue entries");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_left_i) && $stable(out_right_i))
    else $error("stalled result changed");

endmodule

bind stereo_feedback_delay_top sfd_checker u_sfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_left_i  (out_left_o),
  .out_right_i (out_right_o)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the stereo feedback delay line.
module testbench;
  import sfd_pkg::*;

  localparam int unsigned LINE_LEN       = 16384;
  localparam int          LUT_LAST       = 1024;
  localparam int          FB_CEIL        = 18022;
  localparam int          WET_FULL       = 32768;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          PHASE_ITEMS    = 216;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          WATCHDOG_LIMIT = 4000;

  // Edge values for the directed items
  localparam logic [15:0] EDGE_SAMPLES [8] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h4000
  };

  // Tracks both delay lines and the expected mixed pairs
  class echo_tracker;
    bit signed [15:0] left_echo [LINE_LEN];
    bit signed [15:0] right_echo [LINE_LEN];
    bit [13:0]        wr_ptr;
    bit [13:0]        delay_l;
    bit [13:0]        delay_r;
    bit [14:0]        fb_gain;
    bit [15:0]        wet;
    int               tanh_lut [LUT_LAST+1];
    sfd_pair_t        expected_pairs [$];
    int               errors;

    function new();
      logic [63:0]  term;
      logic [63:0]  q;
      logic [63:0]  p;
      logic [63:0]  p40;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  n;
      logic [127:0] prod;
      wr_ptr  = '0;
      delay_l = 14'd8192;
      delay_r = 14'd8192;
      fb_gain = 15'd8192;
      wet     = 16'd16384;
      errors  = 0;
      // q = e^(-1/128) in Q62 from its series
      term = 64'd1 << 62;
      q    = term;
      p    = term;
      for (n = 64'd1; term != 64'd0 && n < 64'd64; n++) begin
        term = term / (64'd128 * n);
        if (n[0]) begin
          q = q - term;
        end else begin
          q = q + term;
        end
      end
      // T(k) = round(32767*(1-p)/(1+p)), p = q^k
      for (int k = 0; k <= LUT_LAST; k++) begin
        p40 = (p + (64'd1 << 21)) >> 22;
        num = 64'd32767 * ((64'd1 << 40) - p40);
        den = (64'd1 << 40) + p40;
        tanh_lut[k] = int'((64'd2 * num + den) / (64'd2 * den));
        prod = {64'd0, p} * {64'd0, q};
        prod = prod + (128'd1 << 61);
        p = prod[125:62];
      end
    endfunction

    // Register write with the same clamping as the block
    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_DELAY_L: delay_l = (val[13:0] == 14'd0) ? 14'd1 : val[13:0];
        CFG_DELAY_R: delay_r = (val[13:0] == 14'd0) ? 14'd1 : val[13:0];
        CFG_GAIN:    fb_gain = (int'(val[14:0]) > FB_CEIL) ? 15'(FB_CEIL) : val[14:0];
        CFG_MIX:     wet = (int'(val) > WET_FULL) ? 16'(WET_FULL) : val;
        default: ;
      endcase
    endfunction

    // (1-mix)*in + mix*delayed, rounded half up and saturated
    function logic signed [15:0] mix_sample(logic signed [15:0] s, logic signed [15:0] d);
      longint acc;
      longint r;
      acc = (longint'(WET_FULL) - longint'(wet)) * longint'(s) + longint'(wet) * longint'(d);
      r = (acc + longint'(16384)) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
    endfunction

    // tanh of in + delayed*gain, argument rounded to Q.8 and saturated to [-4,4)
    function logic signed [15:0] clip_feedback(logic signed [15:0] s, logic signed [15:0] d);
      longint arg;
      longint k;
      arg = longint'(s) * 16384 + longint'(d) * longint'(fb_gain);
      k = (arg + (longint'(1) << 20)) >>> 21;
      if (k < -LUT_LAST) k = -LUT_LAST;
      if (k > LUT_LAST - 1) k = LUT_LAST - 1;
      return (k < 0) ? 16'(-tanh_lut[-k]) : 16'(tanh_lut[k]);
    endfunction

    // Accepted input item: predict the mix, then write back and advance
    function void note_sample_pair(logic signed [15:0] in_l, logic signed [15:0] in_r);
      bit [13:0]          rd_l;
      bit [13:0]          rd_r;
      logic signed [15:0] tap_l;
      logic signed [15:0] tap_r;
      sfd_pair_t          mixed;
      rd_l  = wr_ptr - delay_l;
      rd_r  = wr_ptr - delay_r;
      tap_l = left_echo[rd_l];
      tap_r = right_echo[rd_r];
      mixed.left  = mix_sample(in_l, tap_l);
      mixed.right = mix_sample(in_r, tap_r);
      left_echo[wr_ptr]  = clip_feedback(in_l, tap_l);
      right_echo[wr_ptr] = clip_feedback(in_r, tap_r);
      wr_ptr = wr_ptr + 14'd1;
      expected_pairs.push_back(mixed);
    endfunction

    // Accepted result item against the oldest expectation
    function void check_mixed_pair(logic signed [15:0] got_l, logic signed [15:0] got_r);
      sfd_pair_t want;
      if (expected_pairs.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: left %0d right %0d",
                 $time, got_l, got_r);
        return;
      end
      want = expected_pairs.pop_front();
      if (got_l !== want.left) begin
        errors++;
        $display("%0t: out_left expected %0d, got %0d", $time, want.left, got_l);
      end
      if (got_r !== want.right) begin
        errors++;
        $display("%0t: out_right expected %0d, got %0d", $time, want.right, got_r);
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] in_left_i;
  logic signed [DATA_W-1:0] in_right_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] out_left_o;
  logic signed [DATA_W-1:0] out_right_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i;

  echo_tracker tracker;
  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles;

  stereo_feedback_delay_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Handshake monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_sample_pair(in_left_i, in_right_i);
      if (out_valid_o && !out_stall_i) tracker.check_mixed_pair(out_left_o, out_right_o);
    end
  end

  // Watchdog on handshake and register-write activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item after a random gap and wait until it is taken
  task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_left_i  <= l;
    in_right_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    tracker.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Drain, let write-backs settle, then load all four registers
  task automatic load_settings(logic [15:0] dl, logic [15:0] dr, logic [15:0] g,
                               logic [15:0] m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_DELAY_L, dl);
    write_reg(CFG_DELAY_R, dr);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_MIX, m);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'h3FFF;
      2:       return 16'($urandom);
      3, 4:    return 16'($urandom_range(1, 6));
      default: return 16'($urandom_range(7, 400));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'(FB_CEIL);
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, FB_CEIL));
    endcase
  endfunction

  function automatic logic [15:0] pick_mix();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'(WET_FULL);
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, WET_FULL));
    endcase
  endfunction

  // Mostly full-scale noise, some extremes and some quiet passages
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    tracker      = new();
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_left_i    <= '0;
    in_right_i   <= '0;
    out_stall_i  <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_wdata_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero delays clamp, oversized delays lose their upper bits, gain and mix above their limits
    load_settings(16'h0000, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_pair(EDGE_SAMPLES[i], EDGE_SAMPLES[7-i]);
    load_settings(16'h3FFF, 16'h0001, 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_pair(EDGE_SAMPLES[7-i], EDGE_SAMPLES[i]);
    load_settings(16'h0002, 16'h0005, 16'(FB_CEIL + 1), 16'(WET_FULL + 1));
    for (int i = 0; i < 8; i++) send_pair(EDGE_SAMPLES[i], EDGE_SAMPLES[(i+3)%8]);

    // Random phases, cycling through the idling modes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_settings(pick_delay(), pick_delay(), pick_gain(), pick_mix());
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off mid-phase until every result is out
        if (i == PHASE_ITEMS / 2) wait_drained();
        send_pair(pick_sample(), pick_sample());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
